// ===== hw/rtl/dual_key_node_pool_macros.svh =====
// Assertion macros used by the node pool checker.
`ifndef DUAL_KEY_NODE_POOL_MACROS_SVH
`define DUAL_KEY_NODE_POOL_MACROS_SVH

// Checks the consequent in the same cycle as the antecedent.
`define DKP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("node pool check failed");

// Checks the consequent in the cycle after the antecedent.
`define DKP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("node pool check failed");

`endif

// ===== hw/rtl/dkp_pkg.sv =====
// Package with sizes, codes and shared types of the dual-key node pool.
`timescale 1ns / 1ps

package dkp_pkg;

   localparam int CAPACITY    = 64;
   localparam int HANDLE_BITS = 16;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int KEY_W       = 32;
   localparam int ORDER_W     = 32;
   localparam int PHASE_W     = 16;
   localparam int PERIOD_W    = 16;
   localparam int HANDLE_W    = 16;
   localparam int COUNT_OUT_W = 7;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   typedef enum logic [1:0] {
      REQ_INSERT  = 2'd0,
      REQ_EXTRACT = 2'd1,
      REQ_PRUNE   = 2'd2,
      REQ_PEEK    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FREE,
      ST_BEST,
      ST_PRUNE,
      ST_MIN_LO,
      ST_MIN_UP,
      ST_FINISH
   } state_type;

   // One stored node.
   typedef struct packed {
      logic [KEY_W-1:0]       lower;
      logic [KEY_W-1:0]       upper;
      logic [HANDLE_BITS-1:0] handle;
      logic [ORDER_W-1:0]     order;
   } slot_type;

   // Control from the sequencer to the compare unit.
   typedef struct packed {
      logic clear;
      logic sample;
      logic by_upper;
      logic prune;
   } scan_ctl_type;

   // Result of the compare unit.
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
      slot_type         best;
      logic             hit;
   } scan_res_type;

endpackage

// ===== hw/rtl/dkp_if.sv =====
// Channel interfaces of the dual-key node pool: request, response and register write.
`timescale 1ns / 1ps

interface dkp_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        req_type;
   logic signed [dkp_pkg::KEY_W-1:0]  lower_bound;
   logic signed [dkp_pkg::KEY_W-1:0]  upper_bound;
   logic [dkp_pkg::HANDLE_W-1:0]      node_handle;
   logic signed [dkp_pkg::KEY_W-1:0]  prune_limit;

   modport source (output valid, req_type, lower_bound, upper_bound, node_handle,
                   prune_limit, input ready);
   modport sink   (input valid, req_type, lower_bound, upper_bound, node_handle,
                   prune_limit, output ready);
endinterface

interface dkp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           status;
   logic [dkp_pkg::HANDLE_W-1:0]         out_handle;
   logic signed [dkp_pkg::KEY_W-1:0]     out_lower;
   logic signed [dkp_pkg::KEY_W-1:0]     out_upper;
   logic [dkp_pkg::COUNT_OUT_W-1:0]      pruned_count;
   logic signed [dkp_pkg::KEY_W-1:0]     lowest_lower;
   logic signed [dkp_pkg::KEY_W-1:0]     lowest_upper;
   logic [dkp_pkg::COUNT_OUT_W-1:0]      occupancy;

   modport source (output valid, status, out_handle, out_lower, out_upper, pruned_count,
                   lowest_lower, lowest_upper, occupancy, input ready);
   modport sink   (input valid, status, out_handle, out_lower, out_upper, pruned_count,
                   lowest_lower, lowest_upper, occupancy, output ready);
endinterface

interface dkp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [dkp_pkg::PERIOD_W-1:0]  frequency_period;

   modport source (output valid, frequency_period, input ready);
   modport sink   (input valid, frequency_period, output ready);
endinterface

// ===== hw/rtl/dkp_scan.sv =====
// Shared compare unit: tracks the best node of a pass and tests prune limits.
`timescale 1ns / 1ps

module dkp_scan (
   input  logic                               clock,
   input  logic                               reset,
   input  dkp_pkg::scan_ctl_type              ctl,
   input  dkp_pkg::slot_type                  cand,
   input  logic [dkp_pkg::IDX_W-1:0]          cand_idx,
   input  logic                               cand_live,
   input  logic [dkp_pkg::KEY_W-1:0]          limit,
   input  logic [dkp_pkg::ORDER_W-1:0]        next_order,
   output dkp_pkg::scan_res_type              res
);

   logic                          found_ff;
   logic [dkp_pkg::IDX_W-1:0]     idx_ff;
   dkp_pkg::slot_type             best_ff;

   logic [dkp_pkg::KEY_W-1:0]     key;
   logic [dkp_pkg::KEY_W-1:0]     best_key;
   logic [dkp_pkg::KEY_W-1:0]     op_a;
   logic [dkp_pkg::KEY_W-1:0]     op_b;
   logic [dkp_pkg::ORDER_W-1:0]   cand_age;
   logic [dkp_pkg::ORDER_W-1:0]   best_age;
   logic                          less;
   logic                          take;

   // One signed comparator; a prune compares the limit against the lower bound.
   always_comb begin
      key      = ctl.by_upper ? cand.upper : cand.lower;
      best_key = ctl.by_upper ? best_ff.upper : best_ff.lower;
      op_a     = ctl.prune ? limit : key;
      op_b     = ctl.prune ? cand.lower : best_key;
      less     = $signed(op_a) < $signed(op_b);
      cand_age = next_order - cand.order;
      best_age = next_order - best_ff.order;
      // Equal keys go to the node that was inserted first.
      take     = ctl.sample && cand_live && !ctl.prune &&
                 (!found_ff || less || ((key == best_key) && (cand_age > best_age)));
   end

   // Found flag of the current pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   // Best node so far.
   always_ff @(posedge clock) begin
      if (take) begin
         idx_ff  <= cand_idx;
         best_ff <= cand;
      end
   end

   always_comb begin
      res.found = found_ff;
      res.idx   = idx_ff;
      res.best  = best_ff;
      res.hit   = less;
   end

endmodule

// ===== hw/rtl/dual_key_node_pool.sv =====
// Top level of the dual-key node pool for branch-and-bound search.
//
//   Channel   Direction  Transfer carries
//   req_chan  in         req_type, lower_bound, upper_bound, node_handle, prune_limit
//   rsp_chan  out        status, handle and bounds of an extracted node, prune count,
//                        lowest bounds and occupancy
//   csr_chan  in         frequency_period
//
// Every pass walks all CAPACITY slots through the single read port of the slot
// memory into one compare unit. A peek takes two passes, an extract or a prune three
// (an extract from an empty pool two), an insert a free-slot search plus two passes.
// A synchronous reset empties the pool at once; slot contents are not cleared.
// The request side stays busy until the response register has taken the result;
// a stalled response holds only that register, and register writes are always taken.
`timescale 1ns / 1ps

module dual_key_node_pool (
   input logic        clock,
   input logic        reset,
   dkp_req_if.sink    req_chan,
   dkp_rsp_if.source  rsp_chan,
   dkp_csr_if.sink    csr_chan
);

   dkp_pkg::state_type              state_ff;
   dkp_pkg::state_type              state_in;

   logic [dkp_pkg::CAPACITY-1:0]    valid_ff;
   dkp_pkg::slot_type               slot_mem [dkp_pkg::CAPACITY];
   dkp_pkg::slot_type               rd_data_ff;

   logic [dkp_pkg::IDX_W-1:0]       addr_ff;
   logic [dkp_pkg::IDX_W-1:0]       s1_idx_ff;
   logic                            issue_ff;
   logic                            s1_vld_ff;
   logic                            s1_live_ff;

   logic [dkp_pkg::CNT_W-1:0]       count_ff;
   logic [dkp_pkg::CNT_W-1:0]       pruned_ff;
   logic [dkp_pkg::ORDER_W-1:0]     order_ff;
   logic [dkp_pkg::PHASE_W-1:0]     phase_ff;
   logic [dkp_pkg::PERIOD_W-1:0]    period_ff;
   logic                            by_upper_ff;

   // Latched request.
   dkp_pkg::slot_type               new_slot_ff;
   logic [dkp_pkg::KEY_W-1:0]       limit_ff;

   // Working result.
   dkp_pkg::status_type             status_ff;
   logic [dkp_pkg::HANDLE_BITS-1:0] ext_handle_ff;
   logic [dkp_pkg::KEY_W-1:0]       ext_lower_ff;
   logic [dkp_pkg::KEY_W-1:0]       ext_upper_ff;
   logic [dkp_pkg::KEY_W-1:0]       low_lower_ff;
   logic [dkp_pkg::KEY_W-1:0]       low_upper_ff;

   // Response register.
   logic                            rsp_valid_ff;
   dkp_pkg::status_type             rsp_status_ff;
   logic [dkp_pkg::HANDLE_W-1:0]    rsp_handle_ff;
   logic [dkp_pkg::KEY_W-1:0]       rsp_lower_ff;
   logic [dkp_pkg::KEY_W-1:0]       rsp_upper_ff;
   logic [dkp_pkg::COUNT_OUT_W-1:0] rsp_pruned_ff;
   logic [dkp_pkg::KEY_W-1:0]       rsp_low_lower_ff;
   logic [dkp_pkg::KEY_W-1:0]       rsp_low_upper_ff;
   logic [dkp_pkg::COUNT_OUT_W-1:0] rsp_occ_ff;

   dkp_pkg::req_kind_type           req_kind;
   dkp_pkg::scan_ctl_type           scan_ctl;
   dkp_pkg::scan_res_type           scan_res;
   logic [dkp_pkg::PHASE_W-1:0]     phase_next;
   logic                            use_upper;
   logic                            accept;
   logic                            pass_done;
   logic                            pass_start;
   logic                            ins_write;
   logic                            ins_full;
   logic                            ext_done;
   logic                            lo_done;
   logic                            up_done;
   logic                            rsp_load;
   logic                            prune_drop;

   assign req_kind       = dkp_pkg::req_kind_type'(req_chan.req_type);
   assign accept         = req_chan.valid && req_chan.ready;
   assign pass_done      = !issue_ff && !s1_vld_ff;
   assign req_chan.ready = (state_ff == dkp_pkg::ST_IDLE);
   assign csr_chan.ready = 1'b1;

   // Phase: with period >= 2, every period-th extraction takes the smallest upper bound.
   always_comb begin
      phase_next = phase_ff + dkp_pkg::PHASE_W'(1);
      use_upper  = (period_ff >= dkp_pkg::PERIOD_W'(2)) && (phase_next >= period_ff);
   end

   // Sequencer: next state and pass control.
   always_comb begin
      state_in   = state_ff;
      pass_start = 1'b0;
      ins_write  = 1'b0;
      ins_full   = 1'b0;
      ext_done   = 1'b0;
      lo_done    = 1'b0;
      up_done    = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         dkp_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  dkp_pkg::REQ_INSERT: begin
                     state_in = dkp_pkg::ST_FREE;
                  end
                  dkp_pkg::REQ_EXTRACT: begin
                     pass_start = 1'b1;
                     state_in   = (count_ff == '0) ? dkp_pkg::ST_MIN_LO : dkp_pkg::ST_BEST;
                  end
                  dkp_pkg::REQ_PRUNE: begin
                     pass_start = 1'b1;
                     state_in   = dkp_pkg::ST_PRUNE;
                  end
                  dkp_pkg::REQ_PEEK: begin
                     pass_start = 1'b1;
                     state_in   = dkp_pkg::ST_MIN_LO;
                  end
                  default: begin
                     state_in = dkp_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         dkp_pkg::ST_FREE: begin
            if (!valid_ff[addr_ff]) begin
               ins_write  = 1'b1;
               pass_start = 1'b1;
               state_in   = dkp_pkg::ST_MIN_LO;
            end else if (addr_ff == dkp_pkg::LAST_IDX) begin
               ins_full   = 1'b1;
               pass_start = 1'b1;
               state_in   = dkp_pkg::ST_MIN_LO;
            end
         end
         dkp_pkg::ST_BEST: begin
            if (pass_done) begin
               ext_done   = 1'b1;
               pass_start = 1'b1;
               state_in   = dkp_pkg::ST_MIN_LO;
            end
         end
         dkp_pkg::ST_PRUNE: begin
            if (pass_done) begin
               pass_start = 1'b1;
               state_in   = dkp_pkg::ST_MIN_LO;
            end
         end
         dkp_pkg::ST_MIN_LO: begin
            if (pass_done) begin
               lo_done    = 1'b1;
               pass_start = 1'b1;
               state_in   = dkp_pkg::ST_MIN_UP;
            end
         end
         dkp_pkg::ST_MIN_UP: begin
            if (pass_done) begin
               up_done  = 1'b1;
               state_in = dkp_pkg::ST_FINISH;
            end
         end
         dkp_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = dkp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dkp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dkp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Compare unit control for the current pass.
   always_comb begin
      scan_ctl.clear    = pass_start;
      scan_ctl.sample   = s1_vld_ff && (state_ff == dkp_pkg::ST_BEST ||
                                        state_ff == dkp_pkg::ST_PRUNE ||
                                        state_ff == dkp_pkg::ST_MIN_LO ||
                                        state_ff == dkp_pkg::ST_MIN_UP);
      scan_ctl.by_upper = (state_ff == dkp_pkg::ST_BEST) ? by_upper_ff
                                                         : (state_ff == dkp_pkg::ST_MIN_UP);
      scan_ctl.prune    = (state_ff == dkp_pkg::ST_PRUNE);
      prune_drop        = scan_ctl.prune && s1_vld_ff && s1_live_ff && scan_res.hit;
   end

   dkp_scan u_dkp_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .cand       (rd_data_ff),
      .cand_idx   (s1_idx_ff),
      .cand_live  (s1_live_ff),
      .limit      (limit_ff),
      .next_order (order_ff),
      .res        (scan_res)
   );

   // Address walk: one slot is issued per cycle during a pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff  <= 1'b0;
         s1_vld_ff <= 1'b0;
         addr_ff   <= '0;
      end else begin
         s1_vld_ff <= issue_ff;
         if (pass_start) begin
            issue_ff <= 1'b1;
         end else if (issue_ff && addr_ff == dkp_pkg::LAST_IDX) begin
            issue_ff <= 1'b0;
         end
         if (accept || pass_start) begin
            addr_ff <= '0;
         end else if (issue_ff || state_ff == dkp_pkg::ST_FREE) begin
            addr_ff <= addr_ff + dkp_pkg::IDX_W'(1);
         end
      end
   end

   // Slot memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (ins_write) begin
         slot_mem[addr_ff] <= new_slot_ff;
      end
      if (issue_ff) begin
         rd_data_ff <= slot_mem[addr_ff];
      end
      s1_idx_ff  <= addr_ff;
      s1_live_ff <= valid_ff[addr_ff];
   end

   // Pool state: valid bits, node count, insertion stamp, phase and period.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         count_ff    <= '0;
         order_ff    <= '0;
         phase_ff    <= '0;
         period_ff   <= dkp_pkg::PERIOD_W'(1);
         by_upper_ff <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            period_ff <= csr_chan.frequency_period;
         end
         if (accept && req_kind == dkp_pkg::REQ_EXTRACT && count_ff != '0) begin
            phase_ff    <= use_upper ? '0 : phase_next;
            by_upper_ff <= use_upper;
         end
         if (ins_write) begin
            valid_ff[addr_ff] <= 1'b1;
            count_ff          <= count_ff + dkp_pkg::CNT_W'(1);
            order_ff          <= order_ff + dkp_pkg::ORDER_W'(1);
         end
         if (ext_done) begin
            valid_ff[scan_res.idx] <= 1'b0;
            count_ff               <= count_ff - dkp_pkg::CNT_W'(1);
         end
         if (prune_drop) begin
            valid_ff[s1_idx_ff] <= 1'b0;
            count_ff            <= count_ff - dkp_pkg::CNT_W'(1);
         end
      end
   end

   // Request latch and working result.
   always_ff @(posedge clock) begin
      if (accept) begin
         new_slot_ff.lower  <= req_chan.lower_bound;
         new_slot_ff.upper  <= req_chan.upper_bound;
         new_slot_ff.handle <= dkp_pkg::HANDLE_BITS'(req_chan.node_handle);
         limit_ff           <= req_chan.prune_limit;
         status_ff          <= (req_kind == dkp_pkg::REQ_EXTRACT && count_ff == '0)
                               ? dkp_pkg::STATUS_EMPTY : dkp_pkg::STATUS_OK;
         ext_handle_ff      <= '0;
         ext_lower_ff       <= '0;
         ext_upper_ff       <= '0;
         pruned_ff          <= '0;
      end
      if (accept || ins_write) begin
         new_slot_ff.order <= order_ff;
      end
      if (ins_full) begin
         status_ff <= dkp_pkg::STATUS_FULL;
      end
      if (ext_done) begin
         ext_handle_ff <= scan_res.best.handle;
         ext_lower_ff  <= scan_res.best.lower;
         ext_upper_ff  <= scan_res.best.upper;
      end
      if (prune_drop) begin
         pruned_ff <= pruned_ff + dkp_pkg::CNT_W'(1);
      end
      if (lo_done) begin
         low_lower_ff <= scan_res.found ? scan_res.best.lower : '0;
      end
      if (up_done) begin
         low_upper_ff <= scan_res.found ? scan_res.best.upper : '0;
      end
   end

   // Response register: holds a finished result until its transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff    <= status_ff;
         rsp_handle_ff    <= dkp_pkg::HANDLE_W'(ext_handle_ff);
         rsp_lower_ff     <= ext_lower_ff;
         rsp_upper_ff     <= ext_upper_ff;
         rsp_pruned_ff    <= dkp_pkg::COUNT_OUT_W'(pruned_ff);
         rsp_low_lower_ff <= low_lower_ff;
         rsp_low_upper_ff <= low_upper_ff;
         rsp_occ_ff       <= dkp_pkg::COUNT_OUT_W'(count_ff);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.out_handle   = rsp_handle_ff;
   assign rsp_chan.out_lower    = rsp_lower_ff;
   assign rsp_chan.out_upper    = rsp_upper_ff;
   assign rsp_chan.pruned_count = rsp_pruned_ff;
   assign rsp_chan.lowest_lower = rsp_low_lower_ff;
   assign rsp_chan.lowest_upper = rsp_low_upper_ff;
   assign rsp_chan.occupancy    = rsp_occ_ff;

endmodule

// ===== hw/rtl/dkp_checker.sv =====
// Port checker of the dual-key node pool and its bind to the top level.
`timescale 1ns / 1ps
`include "dual_key_node_pool_macros.svh"

module dkp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [1:0]                          status,
   input logic [dkp_pkg::HANDLE_W-1:0]        out_handle,
   input logic [dkp_pkg::COUNT_OUT_W-1:0]     occupancy,
   input logic [dkp_pkg::KEY_W-1:0]           lowest_lower
);

   localparam logic [dkp_pkg::COUNT_OUT_W-1:0] OCC_FULL =
      dkp_pkg::COUNT_OUT_W'(dkp_pkg::CAPACITY);

   // A request keeps the block busy for at least the cycle after its transfer.
   `DKP_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // An extract from an empty pool returns no node and shows an empty pool.
   `DKP_ASSERT_SAME(a_empty_report, clock, reset, rsp_valid && status == dkp_pkg::STATUS_EMPTY, occupancy == '0 && out_handle == '0)

   // An insert is refused only when every slot is taken.
   `DKP_ASSERT_SAME(a_full_report, clock, reset, rsp_valid && status == dkp_pkg::STATUS_FULL, occupancy == OCC_FULL)

   // A stalled response keeps its result.
   `DKP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(lowest_lower))

endmodule

bind dual_key_node_pool dkp_checker u_dkp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .status       (rsp_chan.status),
   .out_handle   (rsp_chan.out_handle),
   .occupancy    (rsp_chan.occupancy),
   .lowest_lower (rsp_chan.lowest_lower)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the dual-key node pool: directed and random requests against a pool model.
`timescale 1ns / 1ps

module tb_top;
   import dkp_pkg::*;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
   localparam logic signed [KEY_W-1:0] Q_ONE   = 32'h0001_0000;
   // Longest request: free-slot search plus two full scans.
   localparam int SCAN_SPAN = 3 * CAPACITY + 8;

   // One response as the pool model predicts it.
   typedef struct packed {
      status_type                   status;
      logic [HANDLE_W-1:0]          handle;
      logic signed [KEY_W-1:0]      lower;
      logic signed [KEY_W-1:0]      upper;
      logic [COUNT_OUT_W-1:0]       pruned;
      logic signed [KEY_W-1:0]      low_lower;
      logic signed [KEY_W-1:0]      low_upper;
      logic [COUNT_OUT_W-1:0]       occupancy;
   } pool_reply_type;

   logic clock;
   logic reset;

   dkp_req_if req_chan ();
   dkp_rsp_if rsp_chan ();
   dkp_csr_if csr_chan ();

   dual_key_node_pool dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Pool model state.
   logic                     node_used  [CAPACITY];
   logic signed [KEY_W-1:0]  node_lower [CAPACITY];
   logic signed [KEY_W-1:0]  node_upper [CAPACITY];
   logic [HANDLE_BITS-1:0]   node_id    [CAPACITY];
   logic [ORDER_W-1:0]       node_stamp [CAPACITY];
   logic [ORDER_W-1:0]       stamp_next;
   logic [PHASE_W-1:0]       extract_count;
   logic [PERIOD_W-1:0]      period_setting;

   pool_reply_type replies_due [$];
   int error_count   = 0;
   int send_idle_pct = 25;
   int recv_idle_pct = 82;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the pool hangs.
   initial begin : watchdog
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Best occupied slot by the chosen key; the older node wins a tie.
   function automatic int best_node(input bit by_upper);
      int best;
      logic signed [KEY_W-1:0] key, best_key;
      logic [ORDER_W-1:0] age, best_age;
      best = -1;
      best_key = '0;
      best_age = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (node_used[i]) begin
            key = by_upper ? node_upper[i] : node_lower[i];
            age = stamp_next - node_stamp[i];
            if (best < 0 || key < best_key || (key == best_key && age > best_age)) begin
               best = i;
               best_key = key;
               best_age = age;
            end
         end
      end
      return best;
   endfunction

   function automatic int held_count();
      int held;
      held = 0;
      for (int i = 0; i < CAPACITY; i++)
         if (node_used[i]) held++;
      return held;
   endfunction

   // Applies one accepted request to the pool model and queues the response it must produce.
   function automatic void apply_pool_request(input req_kind_type kind,
                                              input logic signed [KEY_W-1:0] lo, up,
                                              input logic [HANDLE_W-1:0] hd,
                                              input logic signed [KEY_W-1:0] lim);
      pool_reply_type r;
      int slot, b, held;
      logic [PHASE_W-1:0] phase;
      bit by_upper;
      r = '0;
      r.status = STATUS_OK;
      slot = -1;
      by_upper = 1'b0;
      case (kind)
         REQ_INSERT: begin
            // Lowest free slot takes the node.
            for (int i = CAPACITY - 1; i >= 0; i--)
               if (!node_used[i]) slot = i;
            if (slot < 0) begin
               r.status = STATUS_FULL;
            end else begin
               node_used[slot]  = 1'b1;
               node_lower[slot] = lo;
               node_upper[slot] = up;
               node_id[slot]    = hd[HANDLE_BITS-1:0];
               node_stamp[slot] = stamp_next;
               stamp_next       = stamp_next + 1;
            end
         end
         REQ_EXTRACT: begin
            if (best_node(1'b0) < 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               // With a period of two or more, every period-th successful extraction goes by the upper bound.
               phase = extract_count + 1'b1;
               if (period_setting >= 2 && phase >= period_setting) begin
                  phase = '0;
                  by_upper = 1'b1;
               end
               extract_count = phase;
               b = best_node(by_upper);
               r.handle = HANDLE_W'(node_id[b]);
               r.lower  = node_lower[b];
               r.upper  = node_upper[b];
               node_used[b] = 1'b0;
            end
         end
         REQ_PRUNE: begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (node_used[i] && lim < node_lower[i]) begin
                  node_used[i] = 1'b0;
                  r.pruned = r.pruned + 1'b1;
               end
            end
         end
         default: ;
      endcase
      held = held_count();
      r.occupancy = COUNT_OUT_W'(held);
      b = best_node(1'b0);
      if (b >= 0) r.low_lower = node_lower[b];
      b = best_node(1'b1);
      if (b >= 0) r.low_upper = node_upper[b];
      replies_due.push_back(r);
   endfunction

   // Keys often from a narrow set so that ties are frequent, plus extremes and full range.
   function automatic logic signed [KEY_W-1:0] random_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 32'(($urandom_range(0, 15) - 8) * 65536);
         4: begin
            case ($urandom_range(0, 3))
               0: return KEY_MIN;
               1: return KEY_MAX;
               2: return '1;
               default: return '0;
            endcase
         end
         5: return 32'($urandom_range(0, 3));
         default: return $urandom;
      endcase
   endfunction

   // Sends one request and updates the model at the transfer.
   task automatic issue_request(input req_kind_type kind,
                                input logic signed [KEY_W-1:0] lo, up,
                                input logic [HANDLE_W-1:0] hd,
                                input logic signed [KEY_W-1:0] lim);
      int gap;
      gap = 0;
      // Mostly short gaps, now and then one long enough to land anywhere in a scan.
      if (send_idle_pct != 0 && $urandom_range(0, 19) == 0)
         gap = $urandom_range(1, SCAN_SPAN);
      else
         while ($urandom_range(0, 99) < send_idle_pct) gap++;
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= kind;
      req_chan.lower_bound <= lo;
      req_chan.upper_bound <= up;
      req_chan.node_handle <= hd;
      req_chan.prune_limit <= lim;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      apply_pool_request(kind, lo, up, hd, lim);
   endtask

   task automatic request_insert(input logic signed [KEY_W-1:0] lo, up,
                                 input logic [HANDLE_W-1:0] hd);
      issue_request(REQ_INSERT, lo, up, hd, $urandom);
   endtask

   task automatic request_extract();
      issue_request(REQ_EXTRACT, $urandom, $urandom, HANDLE_W'($urandom), $urandom);
   endtask

   task automatic request_prune(input logic signed [KEY_W-1:0] lim);
      issue_request(REQ_PRUNE, $urandom, $urandom, HANDLE_W'($urandom), lim);
   endtask

   task automatic request_peek();
      issue_request(REQ_PEEK, $urandom, $urandom, HANDLE_W'($urandom), $urandom);
   endtask

   // Drops the request valid and waits until every response has been taken.
   task automatic wait_for_replies();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   // Register write, only with the pool idle.
   task automatic write_period(input logic [PERIOD_W-1:0] value);
      wait_for_replies();
      @(negedge clock);
      csr_chan.valid            <= 1'b1;
      csr_chan.frequency_period <= value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      period_setting = value;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Empty pool, key extremes, ties on both keys and prune limits at both ends.
   task automatic test_empty_and_ties();
      request_peek();
      request_extract();
      request_prune(32'sd0);
      request_insert(KEY_MIN, KEY_MAX, 16'h0000);
      request_insert(KEY_MAX, KEY_MIN, 16'hFFFF);
      request_insert(Q_ONE, 2 * Q_ONE, 16'h1234);
      request_insert(Q_ONE, 2 * Q_ONE, 16'h5678);
      request_peek();
      request_extract();
      request_extract();
      request_prune(KEY_MAX);
      request_prune(Q_ONE);
      request_extract();
      request_extract();
      request_insert('1, '1, 16'hAAAA);
      request_insert('1, '1, 16'h5555);
      request_prune(KEY_MIN);
      request_insert(KEY_MIN, '0, 16'h0001);
      request_prune(KEY_MIN);
      request_peek();
      request_extract();
   endtask

   // Lower bounds rise while upper bounds fall, so each pick shows which key was used.
   task automatic test_extract_period();
      write_period(16'd2);
      for (int i = 0; i < 4; i++)
         request_insert(32'(i * 65536), 32'((3 - i) * 65536), HANDLE_W'(16'h0100 + i));
      repeat (4) request_extract();
      write_period(16'd0);
      for (int i = 0; i < 2; i++)
         request_insert(32'(i * 65536), 32'((1 - i) * 65536), HANDLE_W'(16'h0200 + i));
      repeat (2) request_extract();
      // Growing the period, then shrinking it below the running phase.
      write_period(16'd6);
      for (int i = 0; i < 3; i++)
         request_insert(32'(i * 65536), 32'((2 - i) * 65536), HANDLE_W'(16'h0300 + i));
      repeat (3) request_extract();
      write_period(16'd2);
      for (int i = 0; i < 2; i++)
         request_insert(32'(i * 65536), 32'((1 - i) * 65536), HANDLE_W'(16'h0400 + i));
      repeat (2) request_extract();
   endtask

   // Fills the pool past its capacity, then drains it one extraction beyond empty.
   task automatic test_fill_and_drain();
      write_period(16'hFFFF);
      while (held_count() < CAPACITY)
         request_insert(random_key(), random_key(), HANDLE_W'($urandom));
      repeat (3) request_insert(random_key(), random_key(), HANDLE_W'($urandom));
      request_peek();
      repeat (CAPACITY + 1) request_extract();
      wait_for_replies();
   endtask

   // Random traffic in stretches that favor filling, draining or a balance of both.
   task automatic test_random_traffic(input int count);
      int mode, held, roll, pick;
      logic signed [KEY_W-1:0] lim;
      mode = 2;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) mode = $urandom_range(0, 2);
         held = held_count();
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            // Prune near a held lower bound so that part of the pool goes.
            lim = random_key();
            if (held != 0 && $urandom_range(0, 3) != 0) begin
               pick = $urandom_range(0, held - 1);
               for (int i = 0; i < CAPACITY; i++) begin
                  if (node_used[i]) begin
                     if (pick == 0) lim = node_lower[i] - 32'($urandom_range(0, 1));
                     pick--;
                  end
               end
            end
            request_prune(lim);
         end else if (roll < 13) begin
            request_peek();
         end else if (roll < (mode == 0 ? 80 : (mode == 1 ? 45 : 58))) begin
            request_insert(random_key(), random_key(), HANDLE_W'($urandom));
         end else begin
            request_extract();
         end
      end
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         error_count++;
      end
   endtask

   // Receiver stalls at random.
   always @(negedge clock)
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   // Each response transfer is checked against the oldest prediction.
   always @(posedge clock) begin : reply_checker
      pool_reply_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (replies_due.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            error_count++;
         end else begin
            want = replies_due.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_chan.status));
            compare_field("out_handle", 32'(want.handle), 32'(rsp_chan.out_handle));
            compare_field("out_lower", want.lower, rsp_chan.out_lower);
            compare_field("out_upper", want.upper, rsp_chan.out_upper);
            compare_field("pruned_count", 32'(want.pruned), 32'(rsp_chan.pruned_count));
            compare_field("lowest_lower", want.low_lower, rsp_chan.lowest_lower);
            compare_field("lowest_upper", want.low_upper, rsp_chan.lowest_upper);
            compare_field("occupancy", 32'(want.occupancy), 32'(rsp_chan.occupancy));
         end
      end
   end

   // Test sequence.
   initial begin
      reset                     = 1'b1;
      req_chan.valid            = 1'b0;
      req_chan.req_type         = REQ_PEEK;
      req_chan.lower_bound      = '0;
      req_chan.upper_bound      = '0;
      req_chan.node_handle      = '0;
      req_chan.prune_limit      = '0;
      rsp_chan.ready            = 1'b0;
      csr_chan.valid            = 1'b0;
      csr_chan.frequency_period = '0;
      foreach (node_used[i]) begin
         node_used[i]  = 1'b0;
         node_lower[i] = '0;
         node_upper[i] = '0;
         node_id[i]    = '0;
         node_stamp[i] = '0;
      end
      stamp_next     = '0;
      extract_count  = '0;
      period_setting = 16'd1;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender mostly busy, receiver mostly stalled.
      send_idle_pct = 25;
      recv_idle_pct = 82;
      test_empty_and_ties();
      test_extract_period();
      write_period(16'd3);
      test_random_traffic(330);

      // Sender mostly idle, receiver mostly ready.
      send_idle_pct = 82;
      recv_idle_pct = 25;
      test_fill_and_drain();
      write_period(PERIOD_W'($urandom_range(3, 9)));
      test_random_traffic(330);

      // Back to back with no stalls.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_period(16'd1);
      test_random_traffic(150);
      write_period(PERIOD_W'($urandom_range(2, 5)));
      test_random_traffic(150);

      wait_for_replies();
      repeat (SCAN_SPAN) @(posedge clock);
      if (error_count == 0 && replies_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/dkp_pkg.sv
hw/rtl/dkp_if.sv
hw/rtl/dkp_scan.sv
hw/rtl/dual_key_node_pool.sv
hw/rtl/dkp_checker.sv
bench/tb_top.sv
